@@ rtl/ilid_pkg.sv @@
package ilid_pkg;

  localparam int PosW        = 4;
  localparam int DataW       = 32;
  localparam int CountOutW   = 5;
  localparam int DefCapacity = 16;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_SHIFT_DN,
    CELL_SHIFT_UP
  } cell_op_t;

  // broadcast to every cell of the row
  typedef struct packed {
    cell_op_t                op;
    logic [PosW-1:0]         pos;
    logic signed [DataW-1:0] data;
  } cell_ctrl_t;

endpackage

@@ rtl/ilid_if.sv @@
interface ilid_in_if;
  import ilid_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              command;
  logic [PosW-1:0]         position;
  logic signed [DataW-1:0] data_in;

  modport source (output valid, output command, output position, output data_in,
                  input ready);
  modport sink   (input valid, input command, input position, input data_in,
                  output ready);
endinterface

interface ilid_out_if;
  import ilid_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic signed [DataW-1:0] data_out;
  logic [CountOutW-1:0]    live_count;

  modport source (output valid, output status, output data_out, output live_count,
                  input ready);
  modport sink   (input valid, input status, input data_out, input live_count,
                  output ready);
endinterface

@@ rtl/indexed_list_insert_delete.sv @@
// Ordered list of signed 32-bit words held in a row of CAPACITY cells, with a live
// count. Each command word (write, delete, insert, read) returns one result word with
// status, read data and the count after the command; rejected commands change nothing.
// A command is accepted every cycle while the result register is free or being drained,
// and its result word is valid on the following cycle: all cells update in parallel in
// the cycle of acceptance, so delete and insert shift the whole row at once.
// Reset clears the row and the count.
module indexed_list_insert_delete #(
  parameter int CAPACITY = ilid_pkg::DefCapacity
) (
  input  logic              clk,
  input  logic              rst_n,
  ilid_in_if.sink           in_ch,
  ilid_out_if.source        out_ch
);
  import ilid_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int IdxW = $clog2(CAPACITY);
  localparam int Pw   = (CntW > PosW) ? CntW : PosW;

  logic [CntW-1:0]         count_r;
  logic [CntW-1:0]         count_nxt;
  logic                    out_valid_r;
  status_t                 status_r;
  logic signed [DataW-1:0] data_r;
  logic [CountOutW-1:0]    live_count_r;

  logic signed [DataW-1:0] cell_val [CAPACITY];
  cell_ctrl_t              ctrl;
  status_t                 status_nxt;
  logic signed [DataW-1:0] rdata_nxt;
  logic                    accept;
  logic [Pw-1:0]           pos_x;
  logic [Pw-1:0]           cnt_x;
  logic                    full;
  logic                    empty;
  cmd_t                    cmd;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cmd         = cmd_t'(in_ch.command);
  assign pos_x       = Pw'(in_ch.position);
  assign cnt_x       = Pw'(count_r);
  assign full        = (count_r == CntW'(CAPACITY));
  assign empty       = (count_r == '0);

  always_comb begin
    status_nxt = ST_OK;
    rdata_nxt  = '0;
    count_nxt  = count_r;
    ctrl.op    = CELL_HOLD;
    ctrl.pos   = in_ch.position;
    ctrl.data  = in_ch.data_in;
    case (cmd)
      CMD_WRITE: begin
        if (pos_x < cnt_x) ctrl.op = CELL_WRITE;
        else status_nxt = ST_RANGE;
      end
      CMD_DELETE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          status_nxt = ST_RANGE;
        end else begin
          ctrl.op   = CELL_SHIFT_DN;
          count_nxt = count_r - CntW'(1);
        end
      end
      CMD_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else if (pos_x > cnt_x) begin
          status_nxt = ST_RANGE;
        end else begin
          ctrl.op   = CELL_SHIFT_UP;
          count_nxt = count_r + CntW'(1);
        end
      end
      CMD_READ: begin
        if (pos_x < cnt_x) rdata_nxt = cell_val[IdxW'(in_ch.position)];
        else status_nxt = ST_RANGE;
      end
      default: status_nxt = ST_OK;
    endcase
    if (!accept) ctrl.op = CELL_HOLD;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DataW-1:0] lower;
    logic signed [DataW-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_val[i+1];
    end
    ilid_cell #(.INDEX(i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .lower_val (lower),
      .upper_val (upper),
      .value     (cell_val[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r     <= status_nxt;
      data_r       <= rdata_nxt;
      live_count_r <= CountOutW'(count_nxt);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.data_out   = data_r;
  assign out_ch.live_count = live_count_r;

endmodule

@@ rtl/ilid_cell.sv @@
module ilid_cell #(
  parameter int INDEX = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ilid_pkg::cell_ctrl_t                ctrl,
  input  logic signed [ilid_pkg::DataW-1:0]   lower_val,
  input  logic signed [ilid_pkg::DataW-1:0]   upper_val,
  output logic signed [ilid_pkg::DataW-1:0]   value
);
  import ilid_pkg::*;

  localparam int IdxW = $clog2(INDEX + 2);
  localparam int Cw   = (IdxW > PosW) ? IdxW : PosW;
  localparam logic [Cw-1:0] MyIdx = Cw'(INDEX);

  logic signed [DataW-1:0] value_r;
  logic signed [DataW-1:0] value_nxt;
  logic [Cw-1:0]           pos_x;
  logic                    at_pos;
  logic                    above_pos;

  assign pos_x     = Cw'(ctrl.pos);
  assign at_pos    = (MyIdx == pos_x);
  assign above_pos = (MyIdx > pos_x);

  always_comb begin
    value_nxt = value_r;
    case (ctrl.op)
      CELL_WRITE: begin
        if (at_pos) value_nxt = ctrl.data;
      end
      // entries past the count are always zero, so the top one pulls in a zero
      CELL_SHIFT_DN: begin
        if (at_pos || above_pos) value_nxt = upper_val;
      end
      CELL_SHIFT_UP: begin
        if (above_pos) value_nxt = lower_val;
        else if (at_pos) value_nxt = ctrl.data;
      end
      default: value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
    end else begin
      value_r <= value_nxt;
    end
  end

  assign value = value_r;

endmodule

@@ tb/ilid_list_check.sv @@
module ilid_list_check
  import ilid_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ilid_in_if          in_ch,
  ilid_out_if         out_ch,
  output int unsigned fail_cnt,
  output int unsigned words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = DefCapacity;

  typedef struct {
    status_t                 status;
    logic signed [DataW-1:0] data;
    logic [CountOutW-1:0]    count;
  } list_result_t;

  logic signed [DataW-1:0] list_mem [CAP];
  int                      list_len;
  list_result_t            result_q [$];

  // updates the list copy and returns the word the block should answer with
  function automatic list_result_t apply_list_cmd(cmd_t op, logic [PosW-1:0] pos,
                                                  logic signed [DataW-1:0] val);
    list_result_t r;
    int           p;
    p        = int'(pos);
    r.status = ST_OK;
    r.data   = '0;
    case (op)
      CMD_WRITE: begin
        if (p < list_len) list_mem[p] = val;
        else r.status = ST_RANGE;
      end
      CMD_DELETE: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (p >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = p; i < list_len - 1; i++) list_mem[i] = list_mem[i + 1];
          list_mem[list_len - 1] = '0;
          list_len--;
        end
      end
      CMD_INSERT: begin
        // full is checked ahead of the index
        if (list_len >= CAP) begin
          r.status = ST_FULL;
        end else if (p > list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = list_len; i > p; i--) list_mem[i] = list_mem[i - 1];
          list_mem[p] = val;
          list_len++;
        end
      end
      default: begin
        if (p < list_len) r.data = list_mem[p];
        else r.status = ST_RANGE;
      end
    endcase
    r.count = CountOutW'(list_len);
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      foreach (list_mem[i]) list_mem[i] = '0;
      list_len = 0;
      result_q.delete();
      fail_cnt = 0;
    end else begin
      // result first: it always belongs to a word taken on an earlier edge
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: result word with nothing expected: status %0d data %0d count %0d",
                   $time, out_ch.status, out_ch.data_out, out_ch.live_count);
        end else begin
          want = result_q.pop_front();
          if (out_ch.status !== want.status) begin
            fail_cnt++;
            $display("%0t: status expected %0d got %0d", $time, want.status, out_ch.status);
          end
          if (out_ch.data_out !== want.data) begin
            fail_cnt++;
            $display("%0t: data_out expected %0d got %0d", $time, want.data,
                     out_ch.data_out);
          end
          if (out_ch.live_count !== want.count) begin
            fail_cnt++;
            $display("%0t: live_count expected %0d got %0d", $time, want.count,
                     out_ch.live_count);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        result_q.push_back(apply_list_cmd(cmd_t'(in_ch.command), in_ch.position,
                                          in_ch.data_in));
    end
    words_pending <= result_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ilid_pkg::*;

  localparam int CAP         = DefCapacity;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 19;
  localparam int PHASE_WORDS = 50;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned err_cnt;
  int unsigned words_pending;
  int unsigned cyc_cnt = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  bit          sink_hold_req = 1'b0;
  int          est_len = 0;

  ilid_in_if  in_ch ();
  ilid_out_if out_ch ();

  indexed_list_insert_delete #(.CAPACITY(CAP)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ilid_list_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_cnt      (err_cnt),
    .words_pending (words_pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(9) == 0) return $urandom_range(30, 8);
    return $urandom_range(3, 1);
  endfunction

  // called right after a rising edge, returns on the edge that takes the word
  task automatic send_word(cmd_t op, logic [PosW-1:0] pos, logic signed [DataW-1:0] val);
    int gap;
    gap = ($urandom_range(99) < src_idle_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= op;
    in_ch.position <= pos;
    in_ch.data_in  <= val;
    do @(posedge clk); while (!in_ch.ready);
    // rough length, only to steer positions toward live entries
    if (op == CMD_DELETE && est_len > 0 && pos < est_len) est_len--;
    if (op == CMD_INSERT && est_len < CAP && pos <= est_len) est_len++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
  endtask

  task automatic send_random(int unsigned w_ins, int unsigned w_del, int unsigned w_wr);
    int unsigned             roll;
    cmd_t                    op;
    logic [PosW-1:0]         pos;
    logic signed [DataW-1:0] val;
    roll = $urandom_range(99);
    if (roll < w_ins) op = CMD_INSERT;
    else if (roll < w_ins + w_del) op = CMD_DELETE;
    else if (roll < w_ins + w_del + w_wr) op = CMD_WRITE;
    else op = CMD_READ;
    if ($urandom_range(99) < 15) pos = PosW'($urandom_range(15));
    else if (op == CMD_INSERT) pos = PosW'($urandom_range((est_len > 15) ? 15 : est_len));
    else pos = (est_len > 0) ? PosW'($urandom_range(est_len - 1)) : '0;
    case ($urandom_range(39))
      0: val = 32'sh8000_0000;
      1: val = 32'sh7fff_ffff;
      2: val = '0;
      3: val = -32'sd1;
      default: val = $urandom;
    endcase
    send_word(op, pos, val);
  endtask

  // result side: random stalls, and one long hold-off when asked for
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (80) @(posedge clk);
      end else if ($urandom_range(99) < sink_stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.command  <= CMD_WRITE;
    in_ch.position <= '0;
    in_ch.data_in  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty list corners
    send_word(CMD_READ,   4'd0,  32'sd5);
    send_word(CMD_WRITE,  4'd0,  32'sd7);
    send_word(CMD_DELETE, 4'd0,  '0);
    send_word(CMD_DELETE, 4'd15, '0);
    send_word(CMD_INSERT, 4'd1,  32'sd9);
    // build front, append and middle inserts
    send_word(CMD_INSERT, 4'd0,  32'sh8000_0000);
    send_word(CMD_INSERT, 4'd1,  32'sh7fff_ffff);
    send_word(CMD_INSERT, 4'd0,  -32'sd1);
    send_word(CMD_INSERT, 4'd2,  '0);
    for (int i = 0; i < 4; i++) send_word(CMD_READ, 4'(i), '0);
    send_word(CMD_WRITE,  4'd3,  32'sh5555_aaaa);
    send_word(CMD_WRITE,  4'd4,  32'sh1234_5678);
    send_word(CMD_READ,   4'd15, '0);
    send_word(CMD_INSERT, 4'd6,  32'sd3);
    send_word(CMD_DELETE, 4'd4,  '0);
    send_word(CMD_DELETE, 4'd1,  '0);
    send_word(CMD_READ,   4'd1,  '0);
    send_word(CMD_READ,   4'd3,  '0);
    send_word(CMD_DELETE, 4'd0,  '0);
    send_word(CMD_READ,   4'd0,  '0);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      src_idle_pct   = (ph % 3 == 0) ? 0 : $urandom_range(50, 10);
      sink_stall_pct = (ph % 5 == 0) ? 0 : $urandom_range(50, 5);
      if (ph == 2) begin
        src_idle_pct  = 0;
        sink_hold_req = 1'b1;
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        case (ph % 4)
          0: send_random(60, 10, 15);  // fill toward full
          1: send_random(25, 25, 25);
          2: send_random(10, 60, 15);  // drain toward empty
          default: send_random(20, 20, 30);
        endcase
      end
      if (ph % 2 == 1) wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (err_cnt == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
